// ===== src/h264_sps_stream_parser_defines.svh =====
// Assertion macros for the SPS stream parser.
// Used by the top level; expects clk and arst_n in scope.
`ifndef H264_SPS_STREAM_PARSER_DEFINES_SVH
`define H264_SPS_STREAM_PARSER_DEFINES_SVH

// expression holds at every edge out of reset
`define H264SPS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define H264SPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/h264sps_pkg.sv =====
// Shared types and constants for the SPS stream parser.
// No dependencies.
package h264sps_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [4:0]  NAL_TYPE_MASK = 5'h1f;
	localparam logic [4:0]  NAL_TYPE_SPS = 5'd7;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_NOSPS = 2'd1;
	localparam logic [1:0] STATUS_ERR   = 2'd2;

	// log2 of SubWidthC / SubHeightC per chroma_format_idc
	localparam logic [1:0] SUB_W_SH [4] = '{2'd0, 2'd1, 2'd1, 2'd0};
	localparam logic [1:0] SUB_H_SH [4] = '{2'd0, 2'd1, 2'd0, 2'd0};

	typedef enum logic [1:0] {OP_BITS, OP_UE, OP_SE} op_t;

	typedef enum logic [3:0] {
		D_NONE, D_PROF, D_LVL, D_CHROMA, D_POC, D_CYC, D_REFS, D_WMB, D_HMU,
		D_FMO, D_CL, D_CR, D_CT, D_CB, D_LIST
	} dest_t;

	typedef enum logic [5:0] {
		ST_SEARCH, ST_HEADER, ST_BODY, ST_COMMIT, ST_IGNORE, ST_OUT,
		ST_PROF, ST_CONS, ST_LVL, ST_SPSID, ST_CHROMA, ST_SEPC, ST_BDL, ST_BDC,
		ST_BYP, ST_SMF, ST_LFLAG, ST_LSE, ST_L2MF, ST_POC, ST_LSB, ST_DAZ,
		ST_ONR, ST_OTB, ST_CYC, ST_OFF, ST_REFS, ST_GAPS, ST_WMB, ST_HMU,
		ST_FMO, ST_MBA, ST_D8, ST_CROPF, ST_CL, ST_CR, ST_CT, ST_CB, ST_FIN
	} state_t;

	typedef struct packed {
		logic       search_byte;
		logic       hdr_fail;
		logic       sps_start;
		logic       body_byte;
		logic       commit;
		logic       flush;
		logic       parse_init;
		logic       rd_start;
		op_t        rd_op;
		logic [3:0] rd_n;
		dest_t      dest;
		logic       lst_clr;
		logic       lst_inc;
		logic       el_clr;
		logic       el_inc;
		logic       cyc_clr;
		logic       cyc_inc;
		logic       fin;
		logic       out_clr;
	} cmd_t;

	typedef struct packed {
		logic b_one;
		logic b_type7;
		logic pzr2;
		logic sps_end;
		logic pend_any;
		logic held_nz;
		logic rd_active;
		logic rd_done;
		logic rd_err;
		logic rd_bit;
		logic high_prof;
		logic chroma3;
		logic poc0;
		logic poc1;
		logic fmo;
		logic lst_end;
		logic el_end;
		logic next_zero;
		logic cyc_end;
	} stat_t;

	function automatic logic is_high_profile(input logic [7:0] p);
		return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
			p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 ||
			p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134 ||
			p == 8'd135;
	endfunction

endpackage

// ===== src/h264_sps_stream_parser.sv =====
// H.264 SPS extractor for an Annex B byte stream: top level.
// Depends on h264sps_pkg, h264sps_ctrl, h264sps_dp and the defines header.
//
// Input channel (s_*): one stream byte per transaction, s_tlast on the final
// byte of a stream. Output channel (m_*): exactly one result transaction per
// stream, raised after the byte carrying s_tlast.
// Bytes outside the SPS are taken one per cycle. A byte inside the SPS is
// taken in ST_BODY, then ST_COMMIT commits any pending bytes to the RBSP store
// (up to four when held zero bytes are released) with no input taken. The
// FNV-1a multiplier works one byte a cycle. When the SPS ends, the parse runs
// bit-serially from the RBSP RAM, each bit addressed and then taken from the
// registered read; no input is taken meanwhile. The result follows the parse,
// or follows the last byte directly when the SPS was already parsed or none
// was found.
// While the result waits on m_tready no input is taken; after its transaction
// the block returns to start-code search with scan, hash, store and result cleared.
// Reset (arst_n low) clears the control, scan, reader and result registers, not the
// syntax fields or the RAM; the RAM needs none since only bytes written for the current SPS are read.
`include "h264_sps_stream_parser_defines.svh"

module h264_sps_stream_parser #(
	parameter int MAX_RBSP_BYTES = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // stream_byte
	input  logic         s_tlast,   // end_of_stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// frame_width[31:0], frame_height[63:32], profile_code[71:64],
	// level_code[79:72], ref_frames[110:80], nal_hash[142:111], zero[143]
	output logic [143:0] m_tdata,
	output logic [1:0]   m_tuser    // status
);

	h264sps_pkg::cmd_t  cmd;
	h264sps_pkg::stat_t stat;
	logic [1:0]  status;
	logic [31:0] frame_width, frame_height, nal_hash;
	logic [7:0]  profile_code, level_code;
	logic [30:0] ref_frames;

	h264sps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	h264sps_dp #(.MAX_RBSP_BYTES(MAX_RBSP_BYTES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream_byte (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.frame_width (frame_width),
		.frame_height(frame_height),
		.profile_code(profile_code),
		.level_code  (level_code),
		.ref_frames  (ref_frames),
		.nal_hash    (nal_hash)
	);

	assign m_tdata = {1'b0, nal_hash, ref_frames, level_code, profile_code,
		frame_height, frame_width};
	assign m_tuser = status;

	`H264SPS_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid), "input taken during result")
	`H264SPS_ASSERT_IMPL(a_status_code, m_tvalid, m_tuser != 2'd3, "illegal status")
	`H264SPS_ASSERT_IMPL(a_ok_size, m_tvalid && m_tuser == h264sps_pkg::STATUS_OK,
		frame_width != 32'd0 && frame_height != 32'd0, "ok with empty size")
	`H264SPS_ASSERT_IMPL(a_fail_zero, m_tvalid && m_tuser != h264sps_pkg::STATUS_OK,
		frame_width == 32'd0 && nal_hash == 32'd0, "failed result not zeroed")

endmodule

// ===== src/h264sps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module h264sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/h264sps_dp.sv =====
// Datapath: start-code scan, FNV-1a hash, RBSP store, bit reader and SPS fields.
// Depends on h264sps_pkg and h264sps_ram.
module h264sps_dp #(
	parameter int MAX_RBSP_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          stream_byte,
	input  h264sps_pkg::cmd_t   cmd,
	output h264sps_pkg::stat_t  stat,
	output logic [1:0]          status,
	output logic [31:0]         frame_width,
	output logic [31:0]         frame_height,
	output logic [7:0]          profile_code,
	output logic [7:0]          level_code,
	output logic [30:0]         ref_frames,
	output logic [31:0]         nal_hash
);

	localparam int CW  = $clog2(MAX_RBSP_BYTES + 1);
	localparam int AW  = $clog2(MAX_RBSP_BYTES);
	localparam int RPW = CW + 3;

	logic [1:0]     pzr_q, held_q, pend_z_q, emu_q;
	logic           pend_b_q;
	logic [7:0]     pend_v_q;
	logic [CW-1:0]  cnt_q;
	logic [31:0]    hash_q;

	logic [RPW-1:0] rd_pos_q;
	logic           active_q, wait_q, done_q, err_q, prefix_q;
	h264sps_pkg::op_t op_q;
	logic [4:0]     zeros_q, left_q;
	logic [31:0]    acc_q;

	logic [7:0]  prof_q, lvl_q, last_q, next_q;
	logic [1:0]  chroma_q;
	logic        chroma_bad_q, poc0_q, poc1_q, fmo_q;
	logic [31:0] cyc_q, ci_q, wmb_q, hmu_q, cl_q, cr_q, ct_q, cb_q;
	logic [30:0] refs_q;
	logic [3:0]  li_q;
	logic [6:0]  ej_q;

	logic [1:0]  res_status_q;
	logic [31:0] res_w_q, res_h_q, res_hash_q;
	logic [7:0]  res_prof_q, res_lvl_q;
	logic [30:0] res_refs_q;

	logic [7:0]    cbyte, hbyte, rdata, nxt;
	logic [31:0]   hin, hmul, vue, rd_val;
	logic          can_store, emu_drop, bit_in, oob, wr_en;
	logic [CW-1:0] rd_byte;

	assign cbyte     = (pend_z_q != 2'd0) ? 8'd0 : pend_v_q;
	assign hbyte     = cmd.sps_start ? stream_byte : cbyte;
	assign hin       = cmd.sps_start ? h264sps_pkg::FNV_BASIS : hash_q;
	assign hmul      = (hin ^ {24'd0, hbyte}) * h264sps_pkg::FNV_PRIME;
	assign can_store = cnt_q < CW'(MAX_RBSP_BYTES);
	assign emu_drop  = (emu_q == 2'd2) && (cbyte == 8'd3);
	assign wr_en     = cmd.commit && can_store && !emu_drop;

	assign rd_byte = rd_pos_q[RPW-1:3];
	assign oob     = rd_byte >= cnt_q;
	assign bit_in  = rdata[3'd7 - rd_pos_q[2:0]];

	h264sps_ram #(.WIDTH(8), .DEPTH(MAX_RBSP_BYTES)) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cnt_q[AW-1:0]),
		.wdata(cbyte),
		.raddr(rd_byte[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		vue = acc_q - 32'd1;
		unique case (op_q)
			h264sps_pkg::OP_BITS: rd_val = acc_q;
			h264sps_pkg::OP_UE:   rd_val = vue;
			h264sps_pkg::OP_SE:   rd_val = vue[0] ? ((vue + 32'd1) >> 1) : (32'd0 - (vue >> 1));
			default:              rd_val = acc_q;
		endcase
	end

	assign nxt = last_q + rd_val[7:0];

	// scan, hash and store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pzr_q    <= '0;
			held_q   <= '0;
			pend_z_q <= '0;
			pend_b_q <= 1'b0;
			emu_q    <= '0;
			cnt_q    <= '0;
			hash_q   <= h264sps_pkg::FNV_BASIS;
		end else if (cmd.out_clr) begin
			pzr_q    <= '0;
			held_q   <= '0;
			pend_z_q <= '0;
			pend_b_q <= 1'b0;
			emu_q    <= '0;
			cnt_q    <= '0;
			hash_q   <= h264sps_pkg::FNV_BASIS;
		end else begin
			if (cmd.search_byte) begin
				if (stream_byte == 8'd0) begin
					pzr_q <= (pzr_q == 2'd2) ? 2'd2 : pzr_q + 2'd1;
				end else begin
					pzr_q <= '0;
				end
			end
			if (cmd.hdr_fail) begin
				pzr_q <= {1'b0, stream_byte == 8'd0};
			end
			if (cmd.sps_start) begin
				hash_q <= hmul;
				held_q <= '0;
				cnt_q  <= '0;
				emu_q  <= '0;
			end
			if (cmd.body_byte) begin
				if (stream_byte == 8'd0) begin
					if (held_q == 2'd3) begin
						pend_z_q <= 2'd1;
					end else begin
						held_q <= held_q + 2'd1;
					end
				end else if (stat.sps_end) begin
					held_q <= '0;
				end else begin
					pend_z_q <= held_q;
					pend_b_q <= 1'b1;
					pend_v_q <= stream_byte;
					held_q   <= '0;
				end
			end
			if (cmd.flush) begin
				pend_z_q <= held_q;
				held_q   <= '0;
			end
			if (cmd.commit) begin
				hash_q <= hmul;
				if (pend_z_q != 2'd0) begin
					pend_z_q <= pend_z_q - 2'd1;
				end else begin
					pend_b_q <= 1'b0;
				end
				if (can_store) begin
					if (emu_drop) begin
						emu_q <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						if (cbyte == 8'd0) begin
							emu_q <= (emu_q == 2'd2) ? 2'd2 : emu_q + 2'd1;
						end else begin
							emu_q <= '0;
						end
					end
				end
			end
		end
	end

	// bit-serial reader: each bit is addressed, then taken from the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			active_q <= 1'b0;
			wait_q   <= 1'b0;
			done_q   <= 1'b0;
			err_q    <= 1'b0;
			prefix_q <= 1'b0;
			op_q     <= h264sps_pkg::OP_BITS;
			zeros_q  <= '0;
			left_q   <= '0;
			acc_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.parse_init) begin
				rd_pos_q <= '0;
				err_q    <= 1'b0;
				active_q <= 1'b0;
			end else if (cmd.rd_start) begin
				active_q <= 1'b1;
				wait_q   <= 1'b0;
				acc_q    <= '0;
				prefix_q <= cmd.rd_op != h264sps_pkg::OP_BITS;
				zeros_q  <= '0;
				left_q   <= {1'b0, cmd.rd_n};
				op_q     <= cmd.rd_op;
			end else if (active_q) begin
				if (!wait_q) begin
					if (oob) begin
						err_q    <= 1'b1;
						active_q <= 1'b0;
						done_q   <= 1'b1;
					end else begin
						wait_q <= 1'b1;
					end
				end else begin
					wait_q   <= 1'b0;
					rd_pos_q <= rd_pos_q + RPW'(1);
					if (prefix_q) begin
						if (!bit_in) begin
							if (zeros_q == 5'd30) begin
								err_q    <= 1'b1;
								active_q <= 1'b0;
								done_q   <= 1'b1;
							end else begin
								zeros_q <= zeros_q + 5'd1;
							end
						end else begin
							acc_q    <= 32'd1;
							left_q   <= zeros_q;
							prefix_q <= 1'b0;
							if (zeros_q == 5'd0) begin
								active_q <= 1'b0;
								done_q   <= 1'b1;
							end
						end
					end else begin
						acc_q  <= {acc_q[30:0], bit_in};
						left_q <= left_q - 5'd1;
						if (left_q == 5'd1) begin
							active_q <= 1'b0;
							done_q   <= 1'b1;
						end
					end
				end
			end
		end
	end

	// syntax fields and loop counters
	always_ff @(posedge clk) begin
		if (cmd.parse_init) begin
			chroma_q     <= 2'd1;
			chroma_bad_q <= 1'b0;
			cl_q <= '0;
			cr_q <= '0;
			ct_q <= '0;
			cb_q <= '0;
		end
		if (done_q && !err_q) begin
			unique case (cmd.dest)
				h264sps_pkg::D_PROF: prof_q <= rd_val[7:0];
				h264sps_pkg::D_LVL:  lvl_q <= rd_val[7:0];
				h264sps_pkg::D_CHROMA: begin
					chroma_q     <= rd_val[1:0];
					chroma_bad_q <= |rd_val[31:2];
				end
				h264sps_pkg::D_POC: begin
					poc0_q <= rd_val == 32'd0;
					poc1_q <= rd_val == 32'd1;
				end
				h264sps_pkg::D_CYC:  cyc_q <= rd_val;
				h264sps_pkg::D_REFS: refs_q <= rd_val[30:0];
				h264sps_pkg::D_WMB:  wmb_q <= rd_val;
				h264sps_pkg::D_HMU:  hmu_q <= rd_val;
				h264sps_pkg::D_FMO:  fmo_q <= rd_val[0];
				h264sps_pkg::D_CL:   cl_q <= rd_val;
				h264sps_pkg::D_CR:   cr_q <= rd_val;
				h264sps_pkg::D_CT:   ct_q <= rd_val;
				h264sps_pkg::D_CB:   cb_q <= rd_val;
				h264sps_pkg::D_LIST: begin
					next_q <= nxt;
					if (nxt != 8'd0) begin
						last_q <= nxt;
					end
				end
				default: ;
			endcase
		end
		if (cmd.lst_clr) begin
			li_q <= '0;
		end
		if (cmd.lst_inc) begin
			li_q <= li_q + 4'd1;
		end
		if (cmd.el_clr) begin
			ej_q   <= '0;
			last_q <= 8'd8;
			next_q <= 8'd8;
		end
		if (cmd.el_inc) begin
			ej_q <= ej_q + 7'd1;
		end
		if (cmd.cyc_clr) begin
			ci_q <= '0;
		end
		if (cmd.cyc_inc) begin
			ci_q <= ci_q + 32'd1;
		end
	end

	// size and cropping
	logic [31:0] wmbp, hmup, cwid, chei, csx, csy, cw, ch;
	logic [1:0]  ysh;
	logic        crop_ok;

	always_comb begin
		wmbp = wmb_q + 32'd1;
		hmup = hmu_q + 32'd1;
		cwid = {wmbp[27:0], 4'd0};
		chei = fmo_q ? {hmup[27:0], 4'd0} : {hmup[26:0], 5'd0};
		csx  = cl_q + cr_q;
		csy  = ct_q + cb_q;
		cw   = (h264sps_pkg::SUB_W_SH[chroma_q] != 2'd0) ? {csx[30:0], 1'b0} : csx;
		ysh  = h264sps_pkg::SUB_H_SH[chroma_q] + {1'b0, !fmo_q};
		unique case (ysh)
			2'd0:    ch = csy;
			2'd1:    ch = {csy[30:0], 1'b0};
			default: ch = {csy[29:0], 2'd0};
		endcase
		crop_ok = !err_q && !chroma_bad_q && (cw < cwid) && (ch < chei);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_status_q <= h264sps_pkg::STATUS_NOSPS;
			res_w_q      <= '0;
			res_h_q      <= '0;
			res_prof_q   <= '0;
			res_lvl_q    <= '0;
			res_refs_q   <= '0;
			res_hash_q   <= '0;
		end else if (cmd.out_clr) begin
			res_status_q <= h264sps_pkg::STATUS_NOSPS;
			res_w_q      <= '0;
			res_h_q      <= '0;
			res_prof_q   <= '0;
			res_lvl_q    <= '0;
			res_refs_q   <= '0;
			res_hash_q   <= '0;
		end else if (cmd.fin) begin
			res_status_q <= crop_ok ? h264sps_pkg::STATUS_OK : h264sps_pkg::STATUS_ERR;
			res_w_q      <= crop_ok ? cwid - cw : '0;
			res_h_q      <= crop_ok ? chei - ch : '0;
			res_prof_q   <= crop_ok ? prof_q : '0;
			res_lvl_q    <= crop_ok ? lvl_q : '0;
			res_refs_q   <= crop_ok ? refs_q : '0;
			res_hash_q   <= crop_ok ? hash_q : '0;
		end
	end

	assign status       = res_status_q;
	assign frame_width  = res_w_q;
	assign frame_height = res_h_q;
	assign profile_code = res_prof_q;
	assign level_code   = res_lvl_q;
	assign ref_frames   = res_refs_q;
	assign nal_hash     = res_hash_q;

	always_comb begin
		stat.b_one     = stream_byte == 8'd1;
		stat.b_type7   = (stream_byte[4:0] & h264sps_pkg::NAL_TYPE_MASK) ==
			h264sps_pkg::NAL_TYPE_SPS;
		stat.pzr2      = pzr_q == 2'd2;
		stat.sps_end   = (stream_byte == 8'd1) && held_q[1];
		stat.pend_any  = (pend_z_q != 2'd0) || pend_b_q;
		stat.held_nz   = held_q != 2'd0;
		stat.rd_active = active_q;
		stat.rd_done   = done_q;
		stat.rd_err    = err_q;
		stat.rd_bit    = rd_val[0];
		stat.high_prof = h264sps_pkg::is_high_profile(prof_q);
		stat.chroma3   = (chroma_q == 2'd3) && !chroma_bad_q;
		stat.poc0      = poc0_q;
		stat.poc1      = poc1_q;
		stat.fmo       = fmo_q;
		stat.lst_end   = li_q == (stat.chroma3 ? 4'd12 : 4'd8);
		stat.el_end    = ej_q == ((li_q < 4'd6) ? 7'd16 : 7'd64);
		stat.next_zero = next_q == 8'd0;
		stat.cyc_end   = ci_q == cyc_q;
	end

endmodule

// ===== src/h264sps_ctrl.sv =====
// Controller: stream phase and SPS syntax sequencer.
// Depends on h264sps_pkg.
module h264sps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  h264sps_pkg::stat_t stat,
	output h264sps_pkg::cmd_t  cmd
);

	h264sps_pkg::state_t state_q, state_d;
	logic eos_q;
	logic acc, idle, dn, ok;

	assign acc  = s_tvalid && s_tready;
	assign idle = !stat.rd_active && !stat.rd_done;
	assign dn   = stat.rd_done;
	assign ok   = stat.rd_done && !stat.rd_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= h264sps_pkg::ST_SEARCH;
			eos_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				eos_q <= s_tlast;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (dn && stat.rd_err) begin
			state_d = h264sps_pkg::ST_FIN;
		end else begin
			unique case (state_q)
				h264sps_pkg::ST_SEARCH:
					if (acc) begin
						if (s_tlast) state_d = h264sps_pkg::ST_OUT;
						else if (stat.b_one && stat.pzr2) state_d = h264sps_pkg::ST_HEADER;
					end
				h264sps_pkg::ST_HEADER:
					if (acc) begin
						if (stat.b_type7) state_d = h264sps_pkg::ST_COMMIT;
						else if (s_tlast) state_d = h264sps_pkg::ST_OUT;
						else state_d = h264sps_pkg::ST_SEARCH;
					end
				h264sps_pkg::ST_BODY:
					if (acc) begin
						state_d = stat.sps_end ? h264sps_pkg::ST_PROF : h264sps_pkg::ST_COMMIT;
					end
				h264sps_pkg::ST_COMMIT:
					if (!stat.pend_any) begin
						if (!eos_q) state_d = h264sps_pkg::ST_BODY;
						else if (!stat.held_nz) state_d = h264sps_pkg::ST_PROF;
					end
				h264sps_pkg::ST_IGNORE:
					if (acc && s_tlast) state_d = h264sps_pkg::ST_OUT;
				h264sps_pkg::ST_OUT:
					if (m_tready) state_d = h264sps_pkg::ST_SEARCH;
				h264sps_pkg::ST_PROF:   if (ok) state_d = h264sps_pkg::ST_CONS;
				h264sps_pkg::ST_CONS:   if (ok) state_d = h264sps_pkg::ST_LVL;
				h264sps_pkg::ST_LVL:    if (ok) state_d = h264sps_pkg::ST_SPSID;
				h264sps_pkg::ST_SPSID:  if (ok) state_d = h264sps_pkg::ST_CHROMA;
				h264sps_pkg::ST_CHROMA:
					if (idle && !stat.high_prof) state_d = h264sps_pkg::ST_L2MF;
					else if (ok) state_d = h264sps_pkg::ST_SEPC;
				h264sps_pkg::ST_SEPC:
					if ((idle && !stat.chroma3) || ok) state_d = h264sps_pkg::ST_BDL;
				h264sps_pkg::ST_BDL:    if (ok) state_d = h264sps_pkg::ST_BDC;
				h264sps_pkg::ST_BDC:    if (ok) state_d = h264sps_pkg::ST_BYP;
				h264sps_pkg::ST_BYP:    if (ok) state_d = h264sps_pkg::ST_SMF;
				h264sps_pkg::ST_SMF:
					if (ok) state_d = stat.rd_bit ? h264sps_pkg::ST_LFLAG : h264sps_pkg::ST_L2MF;
				h264sps_pkg::ST_LFLAG:
					if (idle && stat.lst_end) state_d = h264sps_pkg::ST_L2MF;
					else if (ok && stat.rd_bit) state_d = h264sps_pkg::ST_LSE;
				h264sps_pkg::ST_LSE:
					if (idle && (stat.el_end || stat.next_zero)) state_d = h264sps_pkg::ST_LFLAG;
				h264sps_pkg::ST_L2MF:   if (ok) state_d = h264sps_pkg::ST_POC;
				h264sps_pkg::ST_POC:    if (ok) state_d = h264sps_pkg::ST_LSB;
				h264sps_pkg::ST_LSB:
					if (idle && !stat.poc0) state_d = h264sps_pkg::ST_DAZ;
					else if (ok) state_d = h264sps_pkg::ST_REFS;
				h264sps_pkg::ST_DAZ:
					if (idle && !stat.poc1) state_d = h264sps_pkg::ST_REFS;
					else if (ok) state_d = h264sps_pkg::ST_ONR;
				h264sps_pkg::ST_ONR:    if (ok) state_d = h264sps_pkg::ST_OTB;
				h264sps_pkg::ST_OTB:    if (ok) state_d = h264sps_pkg::ST_CYC;
				h264sps_pkg::ST_CYC:    if (ok) state_d = h264sps_pkg::ST_OFF;
				h264sps_pkg::ST_OFF:
					if (idle && stat.cyc_end) state_d = h264sps_pkg::ST_REFS;
				h264sps_pkg::ST_REFS:   if (ok) state_d = h264sps_pkg::ST_GAPS;
				h264sps_pkg::ST_GAPS:   if (ok) state_d = h264sps_pkg::ST_WMB;
				h264sps_pkg::ST_WMB:    if (ok) state_d = h264sps_pkg::ST_HMU;
				h264sps_pkg::ST_HMU:    if (ok) state_d = h264sps_pkg::ST_FMO;
				h264sps_pkg::ST_FMO:    if (ok) state_d = h264sps_pkg::ST_MBA;
				h264sps_pkg::ST_MBA:
					if ((idle && stat.fmo) || ok) state_d = h264sps_pkg::ST_D8;
				h264sps_pkg::ST_D8:     if (ok) state_d = h264sps_pkg::ST_CROPF;
				h264sps_pkg::ST_CROPF:
					if (ok) state_d = stat.rd_bit ? h264sps_pkg::ST_CL : h264sps_pkg::ST_FIN;
				h264sps_pkg::ST_CL:     if (ok) state_d = h264sps_pkg::ST_CR;
				h264sps_pkg::ST_CR:     if (ok) state_d = h264sps_pkg::ST_CT;
				h264sps_pkg::ST_CT:     if (ok) state_d = h264sps_pkg::ST_CB;
				h264sps_pkg::ST_CB:     if (ok) state_d = h264sps_pkg::ST_FIN;
				h264sps_pkg::ST_FIN:
					state_d = eos_q ? h264sps_pkg::ST_OUT : h264sps_pkg::ST_IGNORE;
				default: state_d = h264sps_pkg::ST_SEARCH;
			endcase
		end
	end

	// outputs
	always_comb begin
		logic rd, skip;
		rd       = 1'b0;
		skip     = 1'b0;
		cmd      = '0;
		cmd.rd_op = h264sps_pkg::OP_UE;
		cmd.dest = h264sps_pkg::D_NONE;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			h264sps_pkg::ST_SEARCH: begin
				s_tready        = 1'b1;
				cmd.search_byte = acc;
			end
			h264sps_pkg::ST_HEADER: begin
				s_tready      = 1'b1;
				cmd.sps_start = acc && stat.b_type7;
				cmd.hdr_fail  = acc && !stat.b_type7;
			end
			h264sps_pkg::ST_BODY: begin
				s_tready       = 1'b1;
				cmd.body_byte  = acc;
				cmd.parse_init = acc && stat.sps_end;
			end
			h264sps_pkg::ST_COMMIT: begin
				cmd.commit     = stat.pend_any;
				cmd.flush      = !stat.pend_any && eos_q && stat.held_nz;
				cmd.parse_init = !stat.pend_any && eos_q && !stat.held_nz;
			end
			h264sps_pkg::ST_IGNORE: s_tready = 1'b1;
			h264sps_pkg::ST_OUT: begin
				m_tvalid    = 1'b1;
				cmd.out_clr = m_tready;
			end
			h264sps_pkg::ST_PROF: begin
				rd = 1'b1; cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd8;
				cmd.dest = h264sps_pkg::D_PROF;
			end
			h264sps_pkg::ST_CONS: begin
				rd = 1'b1; cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd8;
			end
			h264sps_pkg::ST_LVL: begin
				rd = 1'b1; cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd8;
				cmd.dest = h264sps_pkg::D_LVL;
			end
			h264sps_pkg::ST_CHROMA: begin
				rd = 1'b1; skip = !stat.high_prof; cmd.dest = h264sps_pkg::D_CHROMA;
			end
			h264sps_pkg::ST_SEPC: begin
				rd = 1'b1; skip = !stat.chroma3;
				cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd1;
			end
			h264sps_pkg::ST_BYP, h264sps_pkg::ST_DAZ, h264sps_pkg::ST_GAPS,
			h264sps_pkg::ST_MBA, h264sps_pkg::ST_D8, h264sps_pkg::ST_SMF,
			h264sps_pkg::ST_CROPF: begin
				rd = 1'b1; cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd1;
				if (state_q == h264sps_pkg::ST_DAZ) skip = !stat.poc1;
				if (state_q == h264sps_pkg::ST_MBA) skip = stat.fmo;
				cmd.lst_clr = (state_q == h264sps_pkg::ST_SMF) && ok && stat.rd_bit;
			end
			h264sps_pkg::ST_FMO: begin
				rd = 1'b1; cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd1;
				cmd.dest = h264sps_pkg::D_FMO;
			end
			h264sps_pkg::ST_LFLAG: begin
				rd = 1'b1; skip = stat.lst_end;
				cmd.rd_op = h264sps_pkg::OP_BITS; cmd.rd_n = 4'd1;
				cmd.el_clr  = ok && stat.rd_bit;
				cmd.lst_inc = ok && !stat.rd_bit;
			end
			h264sps_pkg::ST_LSE: begin
				rd = 1'b1; skip = stat.el_end || stat.next_zero;
				cmd.rd_op   = h264sps_pkg::OP_SE;
				cmd.dest    = h264sps_pkg::D_LIST;
				cmd.el_inc  = ok;
				cmd.lst_inc = idle && skip;
			end
			h264sps_pkg::ST_SPSID, h264sps_pkg::ST_BDL, h264sps_pkg::ST_BDC,
			h264sps_pkg::ST_L2MF: rd = 1'b1;
			h264sps_pkg::ST_POC: begin
				rd = 1'b1; cmd.dest = h264sps_pkg::D_POC;
			end
			h264sps_pkg::ST_LSB: begin
				rd = 1'b1; skip = !stat.poc0;
			end
			h264sps_pkg::ST_ONR, h264sps_pkg::ST_OTB: begin
				rd = 1'b1; cmd.rd_op = h264sps_pkg::OP_SE;
			end
			h264sps_pkg::ST_CYC: begin
				rd = 1'b1; cmd.dest = h264sps_pkg::D_CYC; cmd.cyc_clr = ok;
			end
			h264sps_pkg::ST_OFF: begin
				rd = 1'b1; skip = stat.cyc_end;
				cmd.rd_op = h264sps_pkg::OP_SE; cmd.cyc_inc = ok;
			end
			h264sps_pkg::ST_REFS: begin rd = 1'b1; cmd.dest = h264sps_pkg::D_REFS; end
			h264sps_pkg::ST_WMB:  begin rd = 1'b1; cmd.dest = h264sps_pkg::D_WMB; end
			h264sps_pkg::ST_HMU:  begin rd = 1'b1; cmd.dest = h264sps_pkg::D_HMU; end
			h264sps_pkg::ST_CL:   begin rd = 1'b1; cmd.dest = h264sps_pkg::D_CL; end
			h264sps_pkg::ST_CR:   begin rd = 1'b1; cmd.dest = h264sps_pkg::D_CR; end
			h264sps_pkg::ST_CT:   begin rd = 1'b1; cmd.dest = h264sps_pkg::D_CT; end
			h264sps_pkg::ST_CB:   begin rd = 1'b1; cmd.dest = h264sps_pkg::D_CB; end
			h264sps_pkg::ST_FIN:  cmd.fin = 1'b1;
			default: ;
		endcase
		cmd.rd_start = rd && idle && !skip;
	end

endmodule
